// ----- hdl/erm_pkg.sv -----
`default_nettype none

package erm_pkg;

   // accumulator widths
   localparam int SSE_W  = 49;
   localparam int RSUM_W = 33;
   localparam int RSS_W  = 47;
   localparam int CNT_W  = 17;

   // serial multiplier: A up to 65 bits, B walked one bit per cycle
   localparam int MUL_A_W   = 65;
   localparam int MUL_B_W   = 32;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_STEPS = MUL_B_W;

   // restoring divider
   localparam int DIV_N_W   = 98;
   localparam int DIV_D_W   = 80;
   localparam int DIV_STEPS = DIV_N_W;

   localparam logic [2:0] STAT_OK    = 3'd0;
   localparam logic [2:0] STAT_OVF   = 3'd1;
   localparam logic [2:0] STAT_DOF   = 3'd2;
   localparam logic [2:0] STAT_CONST = 3'd3;
   localparam logic [2:0] STAT_BOTH  = 3'd4;

   localparam logic [7:0] CSR_FEATURE_COUNT = 8'd0;
   localparam logic [7:0] CSR_DOF_OFFSET    = 8'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC_E,
      ST_ACC_Y,
      ST_M_SQ,
      ST_M_PROD,
      ST_M_SSEN,
      ST_M_AN,
      ST_M_AD,
      ST_D_MSE,
      ST_D_R2,
      ST_D_AR2,
      ST_OUT
   } erm_state_type;

   typedef struct packed {
      logic capture;
      logic add_e;
      logic add_y;
      logic clear;
   } erm_acc_ctl_type;

   typedef struct packed {
      logic [SSE_W-1:0]         sse;
      logic signed [RSUM_W-1:0] real_sum;
      logic [RSS_W-1:0]         rss;
      logic [CNT_W-1:0]         count;
      logic                     ovf;
   } erm_sums_type;

   // Q16.16 of 1 - num/den from quotient q = floor(num*2^16/den), saturated
   function automatic logic [31:0] one_minus(input logic [DIV_N_W-1:0] q,
                                              input logic rem_nz);
      logic [63:0] d64;
      logic [31:0] res;
      d64 = q[63:0] - 64'h10000;
      if (q[DIV_N_W-1:16] == '0) begin
         res = 32'h10000 - {16'b0, q[15:0]} - {31'b0, rem_nz};
      end else if ((|q[DIV_N_W-1:64]) || (d64 > 64'h80000000)) begin
         res = 32'h80000000;
      end else begin
         res = 32'h10000 - q[31:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/erm_accum.sv -----
`default_nettype none

module erm_accum #(
   parameter int MAX_SAMPLES = 65536
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire erm_pkg::erm_acc_ctl_type ctl,
   input  wire logic signed [15:0]      real_value,
   input  wire logic signed [15:0]      predicted_value,
   output erm_pkg::erm_sums_type        sums
);

   logic signed [15:0] y_ff, p_ff;
   logic               full_ff, full_in;
   logic [erm_pkg::SSE_W-1:0]         sse_ff, sse_in;
   logic signed [erm_pkg::RSUM_W-1:0] rsum_ff, rsum_in;
   logic [erm_pkg::RSS_W-1:0]         rss_ff, rss_in;
   logic [erm_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic                              ovf_ff, ovf_in;

   logic signed [16:0] err;
   logic signed [16:0] op;
   logic signed [33:0] sq_full;
   logic [31:0]        sq;

   assign err     = 17'(y_ff) - 17'(p_ff);
   assign op      = ctl.add_e ? err : 17'(y_ff);
   assign sq_full = op * op;
   assign sq      = sq_full[31:0];

   always_comb begin
      full_in = full_ff;
      sse_in  = sse_ff;
      rsum_in = rsum_ff;
      rss_in  = rss_ff;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      if (ctl.capture) begin
         full_in = (cnt_ff == erm_pkg::CNT_W'(MAX_SAMPLES));
      end
      if (ctl.add_e) begin
         if (full_ff) begin
            ovf_in = 1'b1;
         end else begin
            sse_in  = sse_ff + erm_pkg::SSE_W'(sq);
            rsum_in = rsum_ff + erm_pkg::RSUM_W'(y_ff);
            cnt_in  = cnt_ff + 1'b1;
         end
      end
      if (ctl.add_y && !full_ff) begin
         rss_in = rss_ff + erm_pkg::RSS_W'(sq);
      end
      if (ctl.clear) begin
         sse_in  = '0;
         rsum_in = '0;
         rss_in  = '0;
         cnt_in  = '0;
         ovf_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         y_ff <= real_value;
         p_ff <= predicted_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         sse_ff  <= '0;
         rsum_ff <= '0;
         rss_ff  <= '0;
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         full_ff <= full_in;
         sse_ff  <= sse_in;
         rsum_ff <= rsum_in;
         rss_ff  <= rss_in;
         cnt_ff  <= cnt_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign sums.sse      = sse_ff;
   assign sums.real_sum = rsum_ff;
   assign sums.rss      = rss_ff;
   assign sums.count    = cnt_ff;
   assign sums.ovf      = ovf_ff;

endmodule

`default_nettype wire

// ----- hdl/erm_mul.sv -----
`default_nettype none

module erm_mul (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   input  wire logic [erm_pkg::MUL_A_W-1:0]   a,
   input  wire logic [erm_pkg::MUL_B_W-1:0]   b,
   output logic                               done,
   output logic [erm_pkg::MUL_P_W-1:0]        product
);

   logic [erm_pkg::MUL_P_W-1:0] acc_ff, acc_in;
   logic [erm_pkg::MUL_P_W-1:0] a_sh_ff, a_sh_in;
   logic [erm_pkg::MUL_B_W-1:0] b_ff, b_in;
   logic [$clog2(erm_pkg::MUL_STEPS)-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      a_sh_in = a_sh_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_sh_in = erm_pkg::MUL_P_W'(a);
         b_in    = b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift-add, one multiplier bit a cycle
         if (b_ff[0]) begin
            acc_in = acc_ff + a_sh_ff;
         end
         a_sh_in = a_sh_ff << 1;
         b_in    = b_ff >> 1;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(erm_pkg::MUL_STEPS))'(erm_pkg::MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_in_hold: begin
         acc_ff  <= acc_in;
         a_sh_ff <= a_sh_in;
         b_ff    <= b_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

// ----- hdl/erm_div.sv -----
`default_nettype none

module erm_div (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   input  wire logic [erm_pkg::DIV_N_W-1:0]   num,
   input  wire logic [erm_pkg::DIV_D_W-1:0]   den,
   output logic                               done,
   output logic [erm_pkg::DIV_N_W-1:0]        quotient,
   output logic                               rem_nz
);

   logic [erm_pkg::DIV_N_W-1:0] num_ff, num_in;
   logic [erm_pkg::DIV_D_W-1:0] den_ff, den_in;
   logic [erm_pkg::DIV_D_W-1:0] rem_ff, rem_in;
   logic [erm_pkg::DIV_N_W-1:0] q_ff, q_in;
   logic [$clog2(erm_pkg::DIV_STEPS)-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;

   logic [erm_pkg::DIV_D_W:0] rem_sh;
   logic [erm_pkg::DIV_D_W:0] diff;
   logic                      ge;

   assign rem_sh = {rem_ff, num_ff[erm_pkg::DIV_N_W-1]};
   assign diff   = rem_sh - {1'b0, den_ff};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // restoring step, one quotient bit a cycle
         num_in = num_ff << 1;
         rem_in = ge ? diff[erm_pkg::DIV_D_W-1:0] : rem_sh[erm_pkg::DIV_D_W-1:0];
         q_in   = {q_ff[erm_pkg::DIV_N_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(erm_pkg::DIV_STEPS))'(erm_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;
   assign rem_nz   = |rem_ff;

endmodule

`default_nettype wire

// ----- hdl/regression_error_metrics_unit.sv -----
`default_nettype none

// Regression error metrics. Takes (real, predicted) Q8.8 pairs, keeps exact
// sums of squared residuals, reals and squared reals, and on the pair marked
// last returns one word: MSE (Q32.16), R squared and adjusted R squared
// (Q16.16, truncated toward zero, saturated), the pair count and a status
// code; the sums are then cleared. An ordinary pair is accepted, then
// accumulated in ACC_E and ACC_Y through one 17x17 squarer. A last pair
// then runs five products on a shift-add multiplier and three quotients on
// a restoring divider before the result word is loaded. req_stall is high
// while a pair is in work; a loaded result waits in its output register and
// holds back only the next result, not new pairs. csr_ready is always high;
// write registers only while idle.
module regression_error_metrics_unit #(
   parameter int MAX_SAMPLES = 65536,
   parameter int SAMPLE_BITS = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire logic signed [15:0] req_real_value,
   input  wire logic signed [15:0] req_predicted_value,
   input  wire                req_last_sample,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic [47:0]        rsp_mse,
   output logic signed [31:0] rsp_r_squared,
   output logic signed [31:0] rsp_adjusted_r_squared,
   output logic [16:0]        rsp_sample_count,
   output logic [2:0]         rsp_status,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire logic [7:0]    csr_index,
   input  wire logic [7:0]    csr_data
);

   erm_pkg::erm_state_type   state_ff, state_in;
   erm_pkg::erm_acc_ctl_type ctl;
   erm_pkg::erm_sums_type    sums;

   logic [7:0] feature_count_ff, dof_offset_ff;
   logic       last_ff, last_in;

   logic signed [15:0] y_ext, p_ext;

   logic                           mul_start, mul_done;
   logic [erm_pkg::MUL_A_W-1:0]    mul_a;
   logic [erm_pkg::MUL_B_W-1:0]    mul_b;
   logic [erm_pkg::MUL_P_W-1:0]    mul_p;
   logic                           div_start, div_done, div_rnz;
   logic [erm_pkg::DIV_N_W-1:0]    div_num, div_q;
   logic [erm_pkg::DIV_D_W-1:0]    div_den;

   logic [63:0] s1sq_ff, s1sq_in;
   logic [62:0] prod_ff, prod_in;
   logic [64:0] ssen_ff, ssen_in;
   logic [62:0] dn_ff, dn_in;
   logic [81:0] an_ff, an_in;
   logic [79:0] ad_ff, ad_in;
   logic [47:0] mse_ff, mse_in;
   logic [31:0] r2_ff, r2_in;
   logic [31:0] ar2_ff, ar2_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_mse_ff, rsp_mse_in;
   logic [31:0] rsp_r2_ff, rsp_r2_in;
   logic [31:0] rsp_ar2_ff, rsp_ar2_in;
   logic [16:0] rsp_cnt_ff, rsp_cnt_in;
   logic [2:0]  rsp_stat_ff, rsp_stat_in;
   logic        load;

   logic [31:0] ysq;
   logic [32:0] rs_neg;
   logic [17:0] kk;
   logic [16:0] nd;
   logic        dof_bad, const_bad;
   logic [63:0] dn_diff;

   // keep the low SAMPLE_BITS of each sample, sign-extended
   assign y_ext = {{(17 - SAMPLE_BITS){req_real_value[SAMPLE_BITS-1]}},
                   req_real_value[SAMPLE_BITS-2:0]};
   assign p_ext = {{(17 - SAMPLE_BITS){req_predicted_value[SAMPLE_BITS-1]}},
                   req_predicted_value[SAMPLE_BITS-2:0]};

   erm_accum #(.MAX_SAMPLES(MAX_SAMPLES)) u_accum (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .real_value      (y_ext),
      .predicted_value (p_ext),
      .sums            (sums)
   );

   erm_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   erm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_q),
      .rem_nz   (div_rnz)
   );

   assign rs_neg    = 33'(-sums.real_sum);
   assign ysq       = sums.real_sum[32] ? rs_neg[31:0] : sums.real_sum[31:0];
   assign kk        = {1'b0, sums.count} - {10'b0, feature_count_ff}
                      - {10'b0, dof_offset_ff};
   assign nd        = sums.count - {9'b0, dof_offset_ff};
   assign dof_bad   = kk[17] || (kk == '0);
   assign const_bad = (dn_ff == '0);
   assign dn_diff   = {1'b0, prod_ff} - s1sq_ff;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      last_in   = last_ff;
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      s1sq_in   = s1sq_ff;
      prod_in   = prod_ff;
      ssen_in   = ssen_ff;
      dn_in     = dn_ff;
      an_in     = an_ff;
      ad_in     = ad_ff;
      mse_in    = mse_ff;
      r2_in     = r2_ff;
      ar2_in    = ar2_ff;
      load      = 1'b0;
      unique case (state_ff)
         erm_pkg::ST_IDLE: begin
            if (req_valid) begin
               ctl.capture = 1'b1;
               last_in     = req_last_sample;
               state_in    = erm_pkg::ST_ACC_E;
            end
         end
         erm_pkg::ST_ACC_E: begin
            ctl.add_e = 1'b1;
            state_in  = erm_pkg::ST_ACC_Y;
         end
         erm_pkg::ST_ACC_Y: begin
            ctl.add_y = 1'b1;
            if (last_ff) begin
               mul_start = 1'b1;
               mul_a     = erm_pkg::MUL_A_W'(ysq);
               mul_b     = ysq;
               state_in  = erm_pkg::ST_M_SQ;
            end else begin
               state_in = erm_pkg::ST_IDLE;
            end
         end
         erm_pkg::ST_M_SQ: begin
            if (mul_done) begin
               s1sq_in   = mul_p[63:0];
               mul_start = 1'b1;
               mul_a     = erm_pkg::MUL_A_W'(sums.rss);
               mul_b     = erm_pkg::MUL_B_W'(sums.count);
               state_in  = erm_pkg::ST_M_PROD;
            end
         end
         erm_pkg::ST_M_PROD: begin
            if (mul_done) begin
               prod_in   = mul_p[62:0];
               mul_start = 1'b1;
               mul_a     = erm_pkg::MUL_A_W'(sums.sse);
               mul_b     = erm_pkg::MUL_B_W'(sums.count);
               state_in  = erm_pkg::ST_M_SSEN;
            end
         end
         erm_pkg::ST_M_SSEN: begin
            if (mul_done) begin
               ssen_in   = mul_p[64:0];
               // total sum of squares times n, clipped at zero
               dn_in     = ({1'b0, prod_ff} > s1sq_ff) ? dn_diff[62:0] : '0;
               mul_start = 1'b1;
               mul_a     = mul_p[64:0];
               mul_b     = erm_pkg::MUL_B_W'(nd);
               state_in  = erm_pkg::ST_M_AN;
            end
         end
         erm_pkg::ST_M_AN: begin
            if (mul_done) begin
               an_in     = mul_p[81:0];
               mul_start = 1'b1;
               mul_a     = erm_pkg::MUL_A_W'(dn_ff);
               mul_b     = erm_pkg::MUL_B_W'(kk[16:0]);
               state_in  = erm_pkg::ST_M_AD;
            end
         end
         erm_pkg::ST_M_AD: begin
            if (mul_done) begin
               ad_in     = mul_p[79:0];
               div_start = 1'b1;
               div_num   = erm_pkg::DIV_N_W'(sums.sse);
               div_den   = erm_pkg::DIV_D_W'(kk[16:0]);
               state_in  = erm_pkg::ST_D_MSE;
            end
         end
         erm_pkg::ST_D_MSE: begin
            if (div_done) begin
               mse_in    = (|div_q[erm_pkg::DIV_N_W-1:48]) ? '1 : div_q[47:0];
               div_start = 1'b1;
               div_num   = erm_pkg::DIV_N_W'({ssen_ff, 16'b0});
               div_den   = erm_pkg::DIV_D_W'(dn_ff);
               state_in  = erm_pkg::ST_D_R2;
            end
         end
         erm_pkg::ST_D_R2: begin
            if (div_done) begin
               r2_in     = erm_pkg::one_minus(div_q, div_rnz);
               div_start = 1'b1;
               div_num   = {an_ff, 16'b0};
               div_den   = ad_ff;
               state_in  = erm_pkg::ST_D_AR2;
            end
         end
         erm_pkg::ST_D_AR2: begin
            if (div_done) begin
               ar2_in   = erm_pkg::one_minus(div_q, div_rnz);
               state_in = erm_pkg::ST_OUT;
            end
         end
         erm_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load      = 1'b1;
               ctl.clear = 1'b1;
               state_in  = erm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = erm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      rsp_mse_in   = rsp_mse_ff;
      rsp_r2_in    = rsp_r2_ff;
      rsp_ar2_in   = rsp_ar2_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (load) begin
         rsp_cnt_in = sums.count;
         if (sums.ovf) begin
            rsp_stat_in = erm_pkg::STAT_OVF;
            rsp_mse_in  = '0;
            rsp_r2_in   = '0;
            rsp_ar2_in  = '0;
         end else begin
            priority if (dof_bad && const_bad) begin
               rsp_stat_in = erm_pkg::STAT_BOTH;
            end else if (dof_bad) begin
               rsp_stat_in = erm_pkg::STAT_DOF;
            end else if (const_bad) begin
               rsp_stat_in = erm_pkg::STAT_CONST;
            end else begin
               rsp_stat_in = erm_pkg::STAT_OK;
            end
            rsp_mse_in = dof_bad ? '0 : mse_ff;
            rsp_r2_in  = const_bad ? '0 : r2_ff;
            rsp_ar2_in = (const_bad || dof_bad) ? '0 : ar2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= erm_pkg::ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         feature_count_ff <= 8'd0;
         dof_offset_ff    <= 8'd1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_index == erm_pkg::CSR_FEATURE_COUNT) begin
            feature_count_ff <= csr_data;
         end
         if (csr_valid && csr_index == erm_pkg::CSR_DOF_OFFSET) begin
            dof_offset_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      s1sq_ff     <= s1sq_in;
      prod_ff     <= prod_in;
      ssen_ff     <= ssen_in;
      dn_ff       <= dn_in;
      an_ff       <= an_in;
      ad_ff       <= ad_in;
      mse_ff      <= mse_in;
      r2_ff       <= r2_in;
      ar2_ff      <= ar2_in;
      rsp_mse_ff  <= rsp_mse_in;
      rsp_r2_ff   <= rsp_r2_in;
      rsp_ar2_ff  <= rsp_ar2_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign req_stall              = (state_ff != erm_pkg::ST_IDLE);
   assign csr_ready              = 1'b1;
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_mse                = rsp_mse_ff;
   assign rsp_r_squared          = rsp_r2_ff;
   assign rsp_adjusted_r_squared = rsp_ar2_ff;
   assign rsp_sample_count       = rsp_cnt_ff;
   assign rsp_status             = rsp_stat_ff;

endmodule

`default_nettype wire

// ----- hdl/erm_checker.sv -----
`default_nettype none

module erm_checker (
   input wire                clock,
   input wire                reset,
   input wire                req_valid,
   input wire                req_stall,
   input wire                rsp_valid,
   input wire                rsp_stall,
   input wire logic [47:0]   rsp_mse,
   input wire logic signed [31:0] rsp_r_squared,
   input wire logic signed [31:0] rsp_adjusted_r_squared,
   input wire logic [2:0]    rsp_status
);

   // a held word stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // accepted pair keeps the input side busy next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not held off after accept");

   // count overflow reports zero metrics
   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == erm_pkg::STAT_OVF |->
      rsp_mse == '0 && rsp_r_squared == '0 && rsp_adjusted_r_squared == '0)
      else $error("metrics not zero on count overflow");

   // bad degrees of freedom reports zero MSE and adjusted value
   a_dof_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == erm_pkg::STAT_DOF ||
                    rsp_status == erm_pkg::STAT_BOTH) |->
      rsp_mse == '0 && rsp_adjusted_r_squared == '0)
      else $error("mse or adjusted value not zero with bad dof");

endmodule

bind regression_error_metrics_unit erm_checker u_erm_checker (.*);

`default_nettype wire
